>>> sv/utf8dec_pkg.sv
// shared widths, types and lead-byte codes for the utf-8 decoder
`default_nettype none

package utf8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 2;
    localparam int SIX_W  = 6;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // lead byte prefixes, compared against the top bits of the byte
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;

    // continuation bytes still expected after each lead byte
    localparam cnt_t LEAD2_PENDING = 2'd1;
    localparam cnt_t LEAD3_PENDING = 2'd2;
    localparam cnt_t LEAD4_PENDING = 2'd3;
    localparam cnt_t NONE_PENDING  = 2'd0;

endpackage : utf8dec_pkg

`default_nettype wire

>>> sv/utf8_to_code_point_decoder.sv
// lenient utf-8 byte stream to code point decoder with input and result registers
`default_nettype none

// Lenient UTF-8 decoder. One byte enters per item on in_byte; zero or one
// code point leaves per item on code_point. A lead byte 110xxxxx, 1110xxxx
// or 11110xxx starts a sequence of 2, 3 or 4 bytes and gives no result;
// while bytes are pending every byte shifts in its low six bits, its top two
// bits unchecked, and the last one releases the code point. With nothing
// pending, any other byte (ascii, a stray 10xxxxxx, 0xf8 to 0xff, zero) comes
// out as its own value. A new byte is accepted in every cycle in which in_stall
// is low: the sustained rate is one item per clock while the output is not stalled.
// An accepted byte passes through the input register, the single decode step and
// the result register to code_point. in_stall rises only when the input register
// holds a byte and the result register is full and stalled.
module utf8_to_code_point_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire utf8dec_pkg::byte_t in_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output utf8dec_pkg::cp_t        code_point
);
    import utf8dec_pkg::*;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // decode state
    cnt_t pending_reg, pending_next;
    cp_t  acc_reg, acc_next;

    // result register
    logic out_valid_reg, out_valid_next;
    cp_t  code_point_reg, code_point_next;

    logic res_free;   // result register can take a new result
    logic step;       // the held byte goes through the decode step this cycle
    logic in_take;
    cp_t  acc_shift;

    assign res_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && res_free;
    assign in_stall = in_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    assign acc_shift = {acc_reg[CP_W-SIX_W-1:0], in_byte_reg[SIX_W-1:0]};

    // decode step: state update and result selection
    always_comb
    begin
        pending_next    = pending_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        code_point_next = code_point_reg;
        if (step)
        begin
            if (pending_reg != NONE_PENDING)
            begin
                // continuation, top bits not checked
                acc_next     = acc_shift;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == LEAD2_PENDING)
                begin
                    out_valid_next  = 1'b1;
                    code_point_next = acc_shift;
                end
            end
            else if (in_byte_reg[7:5] == LEAD2_PREFIX)
            begin
                acc_next     = CP_W'(in_byte_reg[4:0]);
                pending_next = LEAD2_PENDING;
            end
            else if (in_byte_reg[7:4] == LEAD3_PREFIX)
            begin
                acc_next     = CP_W'(in_byte_reg[3:0]);
                pending_next = LEAD3_PENDING;
            end
            else if (in_byte_reg[7:3] == LEAD4_PREFIX)
            begin
                acc_next     = CP_W'(in_byte_reg[2:0]);
                pending_next = LEAD4_PENDING;
            end
            else
            begin
                // not a lead byte: passes through as its own value
                out_valid_next  = 1'b1;
                code_point_next = CP_W'(in_byte_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= NONE_PENDING;
            acc_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
            acc_reg       <= acc_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
        code_point_reg <= code_point_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;

    // a held byte that cannot move on keeps the input side stalled
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input not stalled while result register is blocked");

    // a continuation that is not the last counts down and gives no new result
    a_mid_sequence_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (pending_reg == LEAD3_PENDING || pending_reg == LEAD4_PENDING))
        |=> (pending_reg == $past(pending_reg) - 2'd1) && !$rose(out_valid_reg))
        else $error("mid-sequence byte mishandled");

    // a two byte lead keeps only five payload bits
    a_lead2_load: assert property (@(posedge clk) disable iff (!rst_n)
        (step && pending_reg == NONE_PENDING && in_byte_reg[7:5] == LEAD2_PREFIX)
        |=> (pending_reg == LEAD2_PENDING) && (acc_reg[CP_W-1:5] == '0))
        else $error("two byte lead loaded wrongly");

    // an ascii byte with nothing pending comes out unchanged next cycle
    a_ascii_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (step && pending_reg == NONE_PENDING && !in_byte_reg[7])
        |=> out_valid_reg && (code_point_reg == CP_W'($past(in_byte_reg))))
        else $error("ascii byte not passed through");

endmodule : utf8_to_code_point_decoder

`default_nettype wire

>>> tb/sv/tb_utf8_to_code_point_decoder.sv
// self-checking testbench for the lenient utf-8 to code point decoder
`default_nettype none

module tb_utf8_to_code_point_decoder;

    import utf8dec_pkg::*;

    // run limits: the block takes one byte per clock when not stalled, so this
    // is far above the slowest correct run, even with every gap and stall
    localparam int RANDOM_BYTES = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int GAP_PERCENT  = 12;

    // tracks decoder state alongside the block and holds the code points
    // still owed by it, oldest first
    class code_point_tracker;
        cnt_t pending;
        cp_t  acc;
        cp_t  due_code_points[$];
        int   n_bytes;
        int   n_checked;
        int   errors;

        function new();
            pending   = NONE_PENDING;
            acc       = '0;
            n_bytes   = 0;
            n_checked = 0;
            errors    = 0;
        endfunction

        // one byte accepted by the block
        function void take_byte(byte_t b);
            n_bytes++;
            if (pending != NONE_PENDING)
            begin
                // top two bits unchecked, low six shifted in
                acc     = cp_t'({acc[CP_W-SIX_W-1:0], b[SIX_W-1:0]});
                pending = pending - 2'd1;
                if (pending == NONE_PENDING)
                    due_code_points.push_back(acc);
            end
            else if (b[7:5] == LEAD2_PREFIX)
            begin
                acc     = cp_t'(b[4:0]);
                pending = LEAD2_PENDING;
            end
            else if (b[7:4] == LEAD3_PREFIX)
            begin
                acc     = cp_t'(b[3:0]);
                pending = LEAD3_PENDING;
            end
            else if (b[7:3] == LEAD4_PREFIX)
            begin
                acc     = cp_t'(b[2:0]);
                pending = LEAD4_PENDING;
            end
            else
            begin
                due_code_points.push_back(cp_t'(b));
            end
        endfunction

        // one code point accepted from the block
        function void check_code_point(cp_t got);
            cp_t want;
            if (due_code_points.size() == 0)
            begin
                $error("code_point 0x%06h arrived with none expected", got);
                errors++;
                return;
            end
            want = due_code_points.pop_front();
            n_checked++;
            if (got !== want)
            begin
                $error("code_point mismatch: expected 0x%06h, actual 0x%06h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    byte_t in_byte = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    cp_t   code_point;

    // random idling on both sides; cleared for a long quiet stretch
    bit    gaps_on = 1'b1;
    int    cycle_count = 0;

    code_point_tracker tracker;

    // directed bytes: zero, ascii extremes, stray continuations, 0xf8 and
    // 0xff, one sequence of each length, the largest 21-bit value, a
    // broken sequence that swallows an ascii byte, and zero as continuation
    byte_t directed_bytes[$] = '{
        8'h00, 8'h41, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hC3, 8'h41,
        8'hE0, 8'h00, 8'h00
    };

    utf8_to_code_point_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point)
    );

    // 12 time unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: values are sampled as they stood before the edge, then
    // the stall for the next cycle is drawn
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_code_point(code_point);
        out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
    end

    // present one byte, with a random gap ahead of it, and hold it until
    // the block takes it; the byte is handed to the tracker on acceptance
    task automatic drive_byte(input byte_t b);
        while (gaps_on && ($urandom_range(0, 99) < GAP_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_byte(b);
    endtask

    // continuation byte with random payload bits
    function automatic byte_t cont_byte();
        return byte_t'(8'h80 | $urandom_range(0, 63));
    endfunction

    // one random run of bytes; mostly well-formed sequences, the rest noise
    // and broken sequences; returns how many bytes were sent
    task automatic drive_random_run(output int sent);
        int    kind;
        int    extra;
        byte_t lead;
        kind = $urandom_range(0, 99);
        sent = 0;
        if (kind < 25)
        begin
            drive_byte(byte_t'($urandom_range(0, 8'h7F)));
            sent = 1;
        end
        else if (kind < 78)
        begin
            // well-formed sequence of 2, 3 or 4 bytes, random payload
            if (kind < 45)
            begin
                lead  = byte_t'(8'hC0 | $urandom_range(0, 31));
                extra = 1;
            end
            else if (kind < 62)
            begin
                lead  = byte_t'(8'hE0 | $urandom_range(0, 15));
                extra = 2;
            end
            else
            begin
                lead  = byte_t'(8'hF0 | $urandom_range(0, 7));
                extra = 3;
            end
            drive_byte(lead);
            repeat (extra) drive_byte(cont_byte());
            sent = extra + 1;
        end
        else if (kind < 86)
        begin
            // broken sequence: any lead, then arbitrary bytes of random count
            case ($urandom_range(0, 2))
                0:       lead = byte_t'(8'hC0 | $urandom_range(0, 31));
                1:       lead = byte_t'(8'hE0 | $urandom_range(0, 15));
                default: lead = byte_t'(8'hF0 | $urandom_range(0, 7));
            endcase
            extra = $urandom_range(0, 3);
            drive_byte(lead);
            repeat (extra) drive_byte(byte_t'($urandom_range(0, 255)));
            sent = extra + 1;
        end
        else if (kind < 92)
        begin
            drive_byte(cont_byte());
            sent = 1;
        end
        else if (kind < 96)
        begin
            drive_byte(byte_t'($urandom_range(8'hF8, 8'hFF)));
            sent = 1;
        end
        else
        begin
            drive_byte(byte_t'($urandom_range(0, 255)));
            sent = 1;
        end
    endtask

    initial
    begin
        int total;
        int run_len;
        tracker = new();
        total   = 0;

        // reset held low, then released on a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            drive_byte(directed_bytes[i]);

        // random part, with a quiet stretch in the middle where neither
        // side idles or stalls
        while (total < RANDOM_BYTES)
        begin
            gaps_on = !(total >= 200 && total < 340);
            drive_random_run(run_len);
            total += run_len;
        end
        gaps_on = 1'b1;
        in_valid <= 1'b0;

        // drain: every owed code point out, then a further wait for strays
        while (tracker.due_code_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes fed, %0d code points checked in order",
                 tracker.n_bytes, tracker.n_checked);
        $display("covered ascii, 2/3/4-byte sequences, stray and high bytes, %s",
                 "broken sequences, random gaps and stalls");
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule : tb_utf8_to_code_point_decoder

`default_nettype wire
